FILE: rtl/rrap_pkg.sv
package rrap_pkg;

  // Parser phases
  typedef enum logic [2:0] {
    PH_ARRAY   = 3'd0,
    PH_COUNT   = 3'd1,
    PH_SKIP    = 3'd2,
    PH_ELEM    = 3'd3,
    PH_LENGTH  = 3'd4,
    PH_PAYLOAD = 3'd5,
    PH_DONE    = 3'd6,
    PH_ERROR   = 3'd7
  } phase_e;

  // Error codes reported in error_kind
  typedef enum logic [2:0] {
    ERR_NONE      = 3'd0,
    ERR_ARRAY_MRK = 3'd1,
    ERR_ELEM_MRK  = 3'd2,
    ERR_NONDIGIT  = 3'd3,
    ERR_TRUNC     = 3'd4,
    ERR_TOO_LARGE = 3'd5
  } err_e;

  // Configuration register indexes
  typedef enum logic [1:0] {
    CFG_ARRAY_MARKER   = 2'd0,
    CFG_ELEMENT_MARKER = 2'd1,
    CFG_NUM_TERMINATOR = 2'd2,
    CFG_LINE_END_BYTE  = 2'd3
  } cfg_idx_e;

  localparam logic [7:0] CFG_ARRAY_MARKER_RST   = 8'd42;
  localparam logic [7:0] CFG_ELEMENT_MARKER_RST = 8'd36;
  localparam logic [7:0] CFG_NUM_TERMINATOR_RST = 8'd13;
  localparam logic [7:0] CFG_LINE_END_BYTE_RST  = 8'd10;

  localparam logic [7:0] ASCII_ZERO = 8'd48;
  localparam logic [7:0] ASCII_NINE = 8'd57;

  localparam int unsigned ACC_W = 16;
  localparam int unsigned ECNT_W = 10;

  typedef struct packed {
    logic [7:0] array_marker;
    logic [7:0] element_marker;
    logic [7:0] number_terminator;
    logic [7:0] line_end_byte;
  } cfg_t;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       end_of_message;
  } in_t;

  typedef struct packed {
    logic [7:0]        out_byte;
    logic              byte_valid;
    logic [ECNT_W-1:0] element_number;
    logic              last_of_element;
    logic              request_done;
    logic [2:0]        error_kind;
  } out_t;

endpackage

FILE: rtl/resp_request_array_parser_unit.sv
// Request array parser: takes a serialised command one byte per item on the
// input channel (data byte plus end-of-message flag) and emits one result
// item per payload byte, per empty element, per zero-count request, per error
// and per truncated request. Bytes that only carry framing give no result.
// Configuration registers (array marker, element marker, number terminator,
// line-end byte) are written through the cfg channel, which is always ready;
// write them only while the block is idle.
// An accepted item is first held in the input register; when the parser
// steps on it, any result it gives is loaded into the result register.
// Throughput: one item per cycle. A single input register feeds the parse
// logic and the result register; the parser state advances once per item.
// When the receiver stalls, the result register holds its item, the input
// register holds the next one, and in_ready_o drops until out_ready_i rises.
// Reset empties both registers, returns the parser to waiting for an array
// marker and loads the default register values.
module resp_request_array_parser_unit #(
  parameter int unsigned MAX_ELEMENTS = 1024,
  parameter int unsigned MAX_LENGTH   = 65535
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           in_valid_i,
  output logic           in_ready_o,
  input  rrap_pkg::in_t  in_data_i,
  output logic           out_valid_o,
  input  logic           out_ready_i,
  output rrap_pkg::out_t out_data_o,
  input  logic           cfg_valid_i,
  output logic           cfg_ready_o,
  input  logic [1:0]     cfg_index_i,
  input  logic [7:0]     cfg_data_i
);

  rrap_pkg::cfg_t cfg_q;
  rrap_pkg::in_t  in_q;
  logic           in_valid_q;
  rrap_pkg::out_t out_q;
  logic           out_valid_q;
  logic           step;
  logic           have;
  rrap_pkg::out_t res;

  assign cfg_ready_o = 1'b1;
  assign step        = in_valid_q && (!out_valid_q || out_ready_i);
  assign in_ready_o  = !in_valid_q || step;
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.array_marker      <= rrap_pkg::CFG_ARRAY_MARKER_RST;
      cfg_q.element_marker    <= rrap_pkg::CFG_ELEMENT_MARKER_RST;
      cfg_q.number_terminator <= rrap_pkg::CFG_NUM_TERMINATOR_RST;
      cfg_q.line_end_byte     <= rrap_pkg::CFG_LINE_END_BYTE_RST;
    end else if (cfg_valid_i) begin
      unique case (rrap_pkg::cfg_idx_e'(cfg_index_i))
        rrap_pkg::CFG_ARRAY_MARKER:   cfg_q.array_marker      <= cfg_data_i;
        rrap_pkg::CFG_ELEMENT_MARKER: cfg_q.element_marker    <= cfg_data_i;
        rrap_pkg::CFG_NUM_TERMINATOR: cfg_q.number_terminator <= cfg_data_i;
        rrap_pkg::CFG_LINE_END_BYTE:  cfg_q.line_end_byte     <= cfg_data_i;
        default: begin
        end
      endcase
    end
  end

  // Input register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (in_ready_o) begin
      in_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      in_q <= in_data_i;
    end
  end

  rrap_parse #(
    .MAX_ELEMENTS(MAX_ELEMENTS),
    .MAX_LENGTH  (MAX_LENGTH)
  ) u_parse (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .step_i(step),
    .item_i(in_q),
    .cfg_i (cfg_q),
    .have_o(have),
    .res_o (res)
  );

  // Result register: load on a result, drop once taken
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (step && have) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (step && have) begin
      out_q <= res;
    end
  end

  a_stall_only_on_full_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_ready_o |-> (out_valid_o && !out_ready_i))
    else $error("input stalled while result register free");

  a_done_no_error: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_data_o.request_done) |->
      (out_data_o.error_kind == rrap_pkg::ERR_NONE))
    else $error("request done together with an error");

  a_payload_error: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_data_o.byte_valid) |->
      (out_data_o.error_kind == rrap_pkg::ERR_NONE ||
       out_data_o.error_kind == rrap_pkg::ERR_TRUNC))
    else $error("payload byte carries a parse error");

  a_idle_byte_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !out_data_o.byte_valid) |-> (out_data_o.out_byte == 8'd0))
    else $error("out_byte set without byte_valid");

endmodule

FILE: rtl/rrap_parse.sv
module rrap_parse #(
  parameter int unsigned MAX_ELEMENTS = 1024,
  parameter int unsigned MAX_LENGTH   = 65535
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          step_i,
  input  rrap_pkg::in_t item_i,
  input  rrap_pkg::cfg_t cfg_i,
  output logic          have_o,
  output rrap_pkg::out_t res_o
);

  localparam int unsigned EW = $clog2(MAX_ELEMENTS + 1);
  localparam logic [19:0] CNT_LIM = 20'(MAX_ELEMENTS);
  localparam logic [19:0] LEN_LIM = 20'((MAX_LENGTH > 65535) ? 65535 : MAX_LENGTH);

  rrap_pkg::phase_e              phase_q, phase_d;
  logic                          skip_pay_q, skip_pay_d;
  logic [rrap_pkg::ACC_W-1:0]    acc_q, acc_d;
  logic [EW-1:0]                 eleft_q, eleft_d;
  logic [15:0]                   bleft_q, bleft_d;
  logic [rrap_pkg::ECNT_W-1:0]   ecnt_q, ecnt_d;

  logic [7:0]  b;
  logic        is_digit;
  logic [3:0]  dig;
  logic [19:0] v;
  logic [19:0] lim;
  logic        is_count;
  logic        fin;
  logic        new_error;
  logic [15:0] bdec;

  always_comb begin
    b        = item_i.data_byte;
    is_digit = (b >= rrap_pkg::ASCII_ZERO) && (b <= rrap_pkg::ASCII_NINE);
    dig      = 4'(b - rrap_pkg::ASCII_ZERO);
    v        = {1'b0, acc_q, 3'b000} + {3'b000, acc_q, 1'b0} + {16'd0, dig};
    is_count = (phase_q == rrap_pkg::PH_COUNT);
    lim      = is_count ? CNT_LIM : LEN_LIM;

    phase_d    = phase_q;
    skip_pay_d = skip_pay_q;
    acc_d      = acc_q;
    eleft_d    = eleft_q;
    bleft_d    = bleft_q;
    ecnt_d     = ecnt_q;
    fin        = 1'b0;
    bdec       = bleft_q;

    have_o               = 1'b0;
    res_o.out_byte       = 8'd0;
    res_o.byte_valid     = 1'b0;
    res_o.element_number = ecnt_q;
    res_o.last_of_element = 1'b0;
    res_o.request_done   = 1'b0;
    res_o.error_kind     = rrap_pkg::ERR_NONE;

    unique case (phase_q)
      rrap_pkg::PH_ARRAY: begin
        if (b == cfg_i.array_marker) begin
          acc_d   = '0;
          ecnt_d  = '0;
          phase_d = rrap_pkg::PH_COUNT;
        end else begin
          have_o           = 1'b1;
          res_o.error_kind = rrap_pkg::ERR_ARRAY_MRK;
          phase_d          = rrap_pkg::PH_ERROR;
        end
      end
      rrap_pkg::PH_COUNT, rrap_pkg::PH_LENGTH: begin
        if (b == cfg_i.number_terminator) begin
          if (is_count) begin
            eleft_d = acc_q[EW-1:0];
            if (acc_q == '0) begin
              have_o             = 1'b1;
              res_o.request_done = 1'b1;
              phase_d            = rrap_pkg::PH_DONE;
            end else begin
              skip_pay_d = 1'b0;
              phase_d    = (cfg_i.number_terminator == cfg_i.line_end_byte) ?
                           rrap_pkg::PH_ELEM : rrap_pkg::PH_SKIP;
            end
          end else begin
            bleft_d    = acc_q;
            skip_pay_d = 1'b1;
            if (cfg_i.number_terminator == cfg_i.line_end_byte) begin
              phase_d = rrap_pkg::PH_PAYLOAD;
              fin     = (acc_q == '0);
            end else begin
              phase_d = rrap_pkg::PH_SKIP;
            end
          end
        end else if (!is_digit) begin
          have_o           = 1'b1;
          res_o.error_kind = rrap_pkg::ERR_NONDIGIT;
          phase_d          = rrap_pkg::PH_ERROR;
        end else if (v > lim) begin
          have_o           = 1'b1;
          res_o.error_kind = rrap_pkg::ERR_TOO_LARGE;
          phase_d          = rrap_pkg::PH_ERROR;
        end else begin
          acc_d = v[rrap_pkg::ACC_W-1:0];
        end
      end
      rrap_pkg::PH_SKIP: begin
        if (b == cfg_i.line_end_byte) begin
          if (!skip_pay_q) begin
            phase_d = rrap_pkg::PH_ELEM;
          end else begin
            phase_d = rrap_pkg::PH_PAYLOAD;
            fin     = (bleft_q == '0);
          end
        end
      end
      rrap_pkg::PH_ELEM: begin
        if (b == cfg_i.element_marker) begin
          acc_d   = '0;
          phase_d = rrap_pkg::PH_LENGTH;
        end else begin
          have_o           = 1'b1;
          res_o.error_kind = rrap_pkg::ERR_ELEM_MRK;
          phase_d          = rrap_pkg::PH_ERROR;
        end
      end
      rrap_pkg::PH_PAYLOAD: begin
        have_o           = 1'b1;
        res_o.out_byte   = b;
        res_o.byte_valid = 1'b1;
        if (bleft_q != '0) begin
          bdec = bleft_q - 16'd1;
        end
        bleft_d = bdec;
        fin     = (bdec == '0);
      end
      rrap_pkg::PH_DONE, rrap_pkg::PH_ERROR: begin
      end
      default: begin
      end
    endcase

    // Close the current element
    if (fin) begin
      have_o                = 1'b1;
      res_o.last_of_element = 1'b1;
      res_o.request_done    = (eleft_q == EW'(1));
      if (eleft_q != '0) begin
        eleft_d = eleft_q - EW'(1);
      end
      ecnt_d = ecnt_q + rrap_pkg::ECNT_W'(1);
      if (eleft_d == '0) begin
        phase_d = rrap_pkg::PH_DONE;
      end else begin
        skip_pay_d = 1'b0;
        phase_d    = rrap_pkg::PH_SKIP;
      end
    end

    // End of message: flag truncation, then rearm for a new request
    new_error = (phase_d == rrap_pkg::PH_ERROR) && (phase_q != rrap_pkg::PH_ERROR);
    if (item_i.end_of_message) begin
      if (!new_error && phase_d != rrap_pkg::PH_DONE && phase_d != rrap_pkg::PH_ERROR) begin
        have_o           = 1'b1;
        res_o.error_kind = rrap_pkg::ERR_TRUNC;
      end
      phase_d    = rrap_pkg::PH_ARRAY;
      skip_pay_d = 1'b0;
      acc_d      = '0;
      eleft_d    = '0;
      bleft_d    = '0;
      ecnt_d     = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q    <= rrap_pkg::PH_ARRAY;
      skip_pay_q <= 1'b0;
      acc_q      <= '0;
      eleft_q    <= '0;
      bleft_q    <= '0;
      ecnt_q     <= '0;
    end else if (step_i) begin
      phase_q    <= phase_d;
      skip_pay_q <= skip_pay_d;
      acc_q      <= acc_d;
      eleft_q    <= eleft_d;
      bleft_q    <= bleft_d;
      ecnt_q     <= ecnt_d;
    end
  end

endmodule
